### rtl/wildcard_byte_pattern_search_top_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_TOP_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, held off while reset is active.
`define WBPS_ASSERT_NOW(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
        else $error("wbps assertion failed");

// Next-cycle implication, held off while reset is active.
`define WBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
        else $error("wbps assertion failed");

`endif

### rtl/wbps_pkg.sv
package wbps_pkg;

    localparam logic       MODE_PATTERN = 1'b0;
    localparam logic       MODE_STREAM  = 1'b1;

    localparam logic [7:0] WILDCARD_BYTE = 8'hFF;

    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] position;
    } out_item_t;

endpackage

### rtl/wbps_match.sv
// Masked parallel compare: lane w checks window byte w against pattern byte w
// (both newest-first), skipping wildcard bytes and lanes past the length.
module wbps_match import wbps_pkg::*; #(
    parameter int PATTERN_MAX = 64,
    parameter int LEN_W       = 7
) (
    input  logic [PATTERN_MAX-1:0][7:0] pattern,
    input  logic [PATTERN_MAX-1:0][7:0] window,
    input  logic [LEN_W-1:0]            length,
    output logic                        hit
);

    always_comb begin
        hit = 1'b1;
        for (int w = 0; w < PATTERN_MAX; w++) begin
            if ((LEN_W'(w) < length) && (pattern[w] != WILDCARD_BYTE)
                && (window[w] != pattern[w])) begin
                hit = 1'b0;
            end
        end
    end

endmodule

### rtl/wildcard_byte_pattern_search_top.sv
// Wildcard byte pattern search. Send pattern bytes with mode 0 (newest last,
// last=1 closes the pattern; 0xFF is a wildcard), then stream bytes with mode 1
// (last=1 ends the stream). Each stream gives at most one result: found with the
// start offset of the first match, not found when the last byte passes, or
// overflow when more than PATTERN_MAX pattern bytes were sent; bytes after an
// answer are dropped silently. The block takes one transfer per clock cycle for
// as long as results are taken: an item is held in an input register, processed
// by a PATTERN_MAX-lane masked compare, and its result is loaded into the output
// register when the result slot is free; m_valid comes straight from that register.
// s_ready follows m_ready combinationally through the single processing stage.
module wildcard_byte_pattern_search_top import wbps_pkg::*; #(
    parameter int PATTERN_MAX = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int              LEN_W   = $clog2(PATTERN_MAX + 1);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(PATTERN_MAX);

    // Input register
    logic     in_valid_reg, in_valid_next;
    in_item_t in_item_reg;

    // Pattern and window shift lines, newest byte at index 0
    logic [PATTERN_MAX-1:0][7:0] pat_reg, pat_next;
    logic [PATTERN_MAX-1:0][7:0] win_reg, win_next;

    // Pattern state
    logic [LEN_W-1:0] len_reg, len_next;
    logic             closed_reg, closed_next;
    logic             ovf_reg, ovf_next;

    // Stream state
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [31:0]      count_reg, count_next;
    logic             done_reg, done_next;

    // Result register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    logic             out_free;
    logic             fire;
    logic             hit;
    logic             has_result;
    out_item_t        result;
    logic [LEN_W-1:0] eff_len;
    logic [PATTERN_MAX-1:0][7:0] win_shift;

    // Advance the processing stage whenever the result slot is free
    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || fire;

    // Window as it stands after the current stream byte enters
    always_comb begin
        win_shift[0] = in_item_reg.data_byte;
        for (int i = 1; i < PATTERN_MAX; i++) begin
            win_shift[i] = win_reg[i-1];
        end
    end

    wbps_match #(
        .PATTERN_MAX(PATTERN_MAX),
        .LEN_W      (LEN_W)
    ) u_match (
        .pattern(pat_reg),
        .window (win_shift),
        .length (len_reg),
        .hit    (hit)
    );

    // Pattern length as seen by an appended byte: a closed pattern restarts
    assign eff_len = closed_reg ? '0 : len_reg;

    always_comb begin
        pat_next    = pat_reg;
        win_next    = win_reg;
        len_next    = len_reg;
        closed_next = closed_reg;
        ovf_next    = ovf_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        has_result  = 1'b0;
        result      = '{status: STATUS_FOUND, position: 32'd0};

        if (fire) begin
            if (in_item_reg.mode == MODE_PATTERN) begin
                if (closed_reg) begin
                    // New pattern: drop the old one and the stream state
                    ovf_next   = 1'b0;
                    fill_next  = '0;
                    count_next = 32'd0;
                    done_next  = 1'b0;
                end
                len_next = eff_len;
                if (eff_len < MAX_LEN) begin
                    pat_next[0] = in_item_reg.data_byte;
                    for (int i = 1; i < PATTERN_MAX; i++) begin
                        pat_next[i] = pat_reg[i-1];
                    end
                    len_next = eff_len + LEN_W'(1);
                end else begin
                    ovf_next = 1'b1;
                end
                closed_next = in_item_reg.last;
            end else begin
                closed_next = 1'b1;
                if (!done_reg) begin
                    if (ovf_reg) begin
                        has_result = 1'b1;
                        result     = '{status: STATUS_OVERFLOW, position: 32'd0};
                    end else if (len_reg == '0) begin
                        has_result = 1'b1;
                    end else begin
                        win_next   = win_shift;
                        count_next = count_reg + 32'd1;
                        if (fill_reg < MAX_LEN) begin
                            fill_next = fill_reg + LEN_W'(1);
                        end
                        if ((fill_next >= len_reg) && hit) begin
                            has_result = 1'b1;
                            result     = '{status: STATUS_FOUND,
                                           position: count_next - 32'(len_reg)};
                        end else if (in_item_reg.last) begin
                            has_result = 1'b1;
                            result     = '{status: STATUS_NOT_FOUND, position: 32'd0};
                        end
                    end
                    if (has_result) begin
                        done_next = 1'b1;
                    end
                end
                // End of stream: next stream starts at offset 0
                if (in_item_reg.last) begin
                    fill_next  = '0;
                    count_next = 32'd0;
                    done_next  = 1'b0;
                end
            end
        end
    end

    // Input register: load on transfer, drop once processed
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    // Result register: load a new result, drop the old one once taken
    always_comb begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (fire && has_result) begin
            out_valid_next = 1'b1;
            out_item_next  = result;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
            closed_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            fill_reg      <= '0;
            count_reg     <= 32'd0;
            done_reg      <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            len_reg       <= len_next;
            closed_reg    <= closed_next;
            ovf_reg       <= ovf_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers; window bytes past the fill count never affect a result
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        pat_reg      <= pat_next;
        win_reg      <= win_next;
        out_item_reg <= out_item_next;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

### rtl/wbps_checker.sv
`include "wildcard_byte_pattern_search_top_assert.svh"

module wbps_checker import wbps_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    logic s_xfer;
    assign s_xfer = s_valid && s_ready && (s_item.mode == MODE_STREAM || s_item.last);

    // Hold a stalled result
    `WBPS_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_valid && !m_ready,
                      m_valid && $stable(m_item))

    // Status is one of the three defined codes
    `WBPS_ASSERT_NOW(a_status_code, aclk, !aresetn, m_valid,
                     m_item.status == STATUS_FOUND || m_item.status == STATUS_NOT_FOUND
                     || m_item.status == STATUS_OVERFLOW)

    // Only found carries an offset
    `WBPS_ASSERT_NOW(a_pos_zero, aclk, !aresetn, m_valid && m_item.status != STATUS_FOUND,
                     m_item.position == 32'd0)

    // No result appears without an earlier stream byte or closing pattern byte: the pipe is two stages deep
    `WBPS_ASSERT_NEXT(a_no_early_result, aclk, !aresetn, !m_valid && !$past(s_xfer),
                      !m_valid || $past(s_valid))

endmodule

bind wildcard_byte_pattern_search_top wbps_checker u_wbps_checker (.*);
